// ===== hdl/slx_pkg.sv =====
// Shared types and constants for the script lexer.
package slx_pkg;

  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_ERROR  = 6'd38;
  localparam logic [5:0] K_EOF    = 6'd39;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_STRING = 2'd1;
  localparam logic [1:0] ERR_CHAR   = 2'd2;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b00000001,
    M_COMMENT = 8'b00000010,
    M_SLASH   = 8'b00000100,
    M_OPER    = 8'b00001000,
    M_STRING  = 8'b00010000,
    M_INT     = 8'b00100000,
    M_FRAC    = 8'b01000000,
    M_IDENT   = 8'b10000000
  } mode_t;

  // One token request as it travels from scanner to output queue.
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] line;
    logic [1:0]  err;
    logic        last;
  } tok_t;

  function automatic logic [5:0] oper_kind(input logic [7:0] c);
    case (c)
      8'h21:   oper_kind = 6'd11;
      8'h3D:   oper_kind = 6'd13;
      8'h3E:   oper_kind = 6'd15;
      default: oper_kind = 6'd17;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      8'h28:   single_kind = 6'd0;
      8'h29:   single_kind = 6'd1;
      8'h7B:   single_kind = 6'd2;
      8'h7D:   single_kind = 6'd3;
      8'h2C:   single_kind = 6'd4;
      8'h2E:   single_kind = 6'd5;
      8'h2D:   single_kind = 6'd6;
      8'h2B:   single_kind = 6'd7;
      8'h3B:   single_kind = 6'd8;
      8'h2A:   single_kind = 6'd10;
      default: single_kind = K_ERROR;
    endcase
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                || (c == 8'h5F);
  endfunction

  // Keyword lookup; window packs first six letters, first at low byte.
  function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (w == 48'h6669) k = 6'd28;
        if (w == 48'h726F) k = 6'd30;
      end
      3'd3: begin
        if (w == 48'h646E61) k = 6'd22;
        if (w == 48'h726F66) k = 6'd26;
        if (w == 48'h6E7566) k = 6'd27;
        if (w == 48'h6C696E) k = 6'd29;
        if (w == 48'h726176) k = 6'd36;
      end
      3'd4: begin
        if (w == 48'h65736C65) k = 6'd24;
        if (w == 48'h73696874) k = 6'd34;
        if (w == 48'h65757274) k = 6'd35;
      end
      3'd5: begin
        if (w == 48'h7373616C63) k = 6'd23;
        if (w == 48'h65736C6166) k = 6'd25;
        if (w == 48'h746E697270) k = 6'd31;
        if (w == 48'h7265707573) k = 6'd33;
        if (w == 48'h656C696877) k = 6'd37;
      end
      3'd6: begin
        if (w == 48'h6E7275746572) k = 6'd32;
      end
      default: k = K_IDENT;
    endcase
    word_kind = k;
  endfunction

endpackage

// ===== hdl/script_lexer_top.sv =====
// Top level of the script lexer: scanner front end feeding a token queue.
//
// Usage:
//   Input side is a queue write port: drive in_char_code, in_byte_valid and
//   in_end_of_source with in_push; the request is taken on a clock edge with
//   in_push high and in_full low. A zero byte or in_end_of_source ends the
//   source; pending token and EOF follow, later requests yield nothing.
//   Output side is a queue read port: while out_empty is low the oldest token
//   sits on out_*; it leaves on a clock edge with out_pop high.
// Timing:
//   One input request per cycle sustained while in_full is low. A byte may
//   make up to three tokens; they are written into an 8-entry queue in the
//   same cycle and drained at one per cycle while out_pop is high, so
//   mostly single-token traffic runs at full rate. in_full rises while
//   fewer than three free entries remain; a stalled reader therefore backs
//   up the writer without losing tokens.
// Reset:
//   rst_n low (synchronous) empties the queue, sets the scanner idle at
//   offset 0, line 1, and reopens the stream.
module script_lexer_top #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_byte_valid,
  input  logic        in_end_of_source,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [15:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);
  import slx_pkg::*;

  logic       room3, take;
  logic [1:0] n_tok;
  tok_t       t0, t1, t2, head;

  assign in_full = !room3;
  assign take    = in_push && room3;

  slx_front #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst_n, .take,
    .char_code(in_char_code), .byte_valid(in_byte_valid),
    .end_of_source(in_end_of_source),
    .n_tok, .tok0(t0), .tok1(t1), .tok2(t2)
  );

  slx_queue #(.DEPTH_BITS(3)) u_queue (
    .clk, .rst_n, .n_in(n_tok), .in0(t0), .in1(t1), .in2(t2),
    .pop(out_pop), .empty(out_empty), .room3, .head
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start[15:0];
  assign out_token_length = head.length[15:0];
  assign out_line_number  = head.line[15:0];
  assign out_error_code   = head.err;
  assign out_last_of_run  = head.last;

  // Tokens only arise from accepted requests.
  a_tok_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    (n_tok != 2'd0) |-> take) else $error("token without request");

  // Final token of a burst carries the last mark; checked for single-token bursts.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (n_tok == 2'd1) |-> t0.last) else $error("missing last mark");

  // Errors report zero offset and length.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_token_kind == K_ERROR) |-> (out_token_start == 16'd0 &&
     out_token_length == 16'd0)) else $error("error token with extent");
endmodule

// ===== hdl/slx_front.sv =====
// Scanner front end: takes one byte per request, emits up to three tokens.
module slx_front #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    char_code,
  input  logic          byte_valid,
  input  logic          end_of_source,
  output logic [1:0]    n_tok,
  output slx_pkg::tok_t tok0,
  output slx_pkg::tok_t tok1,
  output slx_pkg::tok_t tok2
);
  import slx_pkg::*;

  localparam logic [POSITION_BITS-1:0] PMAX = '1;
  localparam logic [LINE_BITS-1:0]     LMAX = '1;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, start_r, start_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [47:0]              kw_r, kw_nxt;
  logic [7:0]               op_r, op_nxt;
  logic                     fin_r, fin_nxt;
  logic [POSITION_BITS-1:0] pos_inc, len_cur, len_inc;
  logic [LINE_BITS-1:0]     line_inc;
  logic [2:0]               kw_len;
  logic                     ends, fresh;
  tok_t                     t [3];
  logic [1:0]               cnt;
  logic [5:0]               sk;

  assign pos_inc  = (pos_r == PMAX) ? pos_r : pos_r + 1'b1;
  assign line_inc = (line_r == LMAX) ? line_r : line_r + 1'b1;
  assign len_cur  = pos_r - start_r;
  assign len_inc  = pos_inc - start_r;
  assign kw_len   = (len_cur > POSITION_BITS'(6)) ? 3'd7 : len_cur[2:0];

  always_comb begin
    mode_nxt = mode_r; pos_nxt = pos_r; start_nxt = start_r; line_nxt = line_r;
    kw_nxt = kw_r; op_nxt = op_r; fin_nxt = fin_r;
    cnt = 2'd0; fresh = 1'b0; sk = single_kind(char_code);
    for (int i = 0; i < 3; i++) t[i] = '0;
    ends = end_of_source || (byte_valid && char_code == 8'h00);
    if (take && !fin_r) begin
      if (byte_valid && char_code != 8'h00) begin
        case (mode_r)
          M_COMMENT: begin
            if (char_code == 8'h0A) begin
              line_nxt = line_inc; mode_nxt = M_IDLE;
            end
            pos_nxt = pos_inc;
          end
          M_SLASH: begin
            if (char_code == 8'h2F) begin
              mode_nxt = M_COMMENT; pos_nxt = pos_inc;
            end else begin
              t[0] = '{K_SLASH, 32'(start_r), 32'(len_cur), 32'(line_r), ERR_NONE, 1'b0};
              cnt = 2'd1; fresh = 1'b1;
            end
          end
          M_OPER: begin
            if (char_code == 8'h3D) begin
              pos_nxt = pos_inc; mode_nxt = M_IDLE;
              t[0] = '{oper_kind(op_r) + 6'd1, 32'(start_r), 32'(len_inc),
                       32'(line_r), ERR_NONE, 1'b0};
              cnt = 2'd1;
            end else begin
              t[0] = '{oper_kind(op_r), 32'(start_r), 32'(len_cur), 32'(line_r),
                       ERR_NONE, 1'b0};
              cnt = 2'd1; fresh = 1'b1;
            end
          end
          M_STRING: begin
            pos_nxt = pos_inc;
            if (char_code == 8'h22) begin
              mode_nxt = M_IDLE; cnt = 2'd1;
              t[0] = '{K_STRING, 32'(start_r), 32'(len_inc), 32'(line_r), ERR_NONE, 1'b0};
            end else if (char_code == 8'h0A) begin
              mode_nxt = M_IDLE; cnt = 2'd1;
              t[0] = '{K_ERROR, 32'd0, 32'd0, 32'(line_r), ERR_STRING, 1'b0};
            end
          end
          M_INT, M_FRAC: begin
            if (is_dec(char_code)) pos_nxt = pos_inc;
            else if (mode_r == M_INT && char_code == 8'h2E) begin
              mode_nxt = M_FRAC; pos_nxt = pos_inc;
            end else begin
              t[0] = '{K_NUMBER, 32'(start_r), 32'(len_cur), 32'(line_r), ERR_NONE, 1'b0};
              cnt = 2'd1; fresh = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_letter(char_code) || is_dec(char_code)) begin
              if (kw_len < 3'd6) kw_nxt = kw_r | (48'(char_code) << {kw_len, 3'b000});
              pos_nxt = pos_inc;
            end else begin
              t[0] = '{word_kind(kw_r, kw_len), 32'(start_r), 32'(len_cur),
                       32'(line_r), ERR_NONE, 1'b0};
              cnt = 2'd1; fresh = 1'b1;
            end
          end
          default: fresh = 1'b1;
        endcase
        if (fresh) begin
          start_nxt = pos_r; mode_nxt = M_IDLE; pos_nxt = pos_inc;
          if (char_code == 8'h0A) line_nxt = line_inc;
          else if (char_code == 8'h20 || char_code == 8'h09 || char_code == 8'h0D) begin
          end else if (is_dec(char_code)) mode_nxt = M_INT;
          else if (is_letter(char_code)) begin
            kw_nxt = 48'(char_code); mode_nxt = M_IDENT;
          end else if (char_code == 8'h2F) mode_nxt = M_SLASH;
          else if (char_code == 8'h21 || char_code == 8'h3D || char_code == 8'h3C
                   || char_code == 8'h3E) begin
            op_nxt = char_code; mode_nxt = M_OPER;
          end else if (char_code == 8'h22) mode_nxt = M_STRING;
          else begin
            if (sk != K_ERROR)
              t[cnt] = '{sk, 32'(pos_r), 32'(pos_inc - pos_r), 32'(line_r), ERR_NONE, 1'b0};
            else
              t[cnt] = '{K_ERROR, 32'd0, 32'd0, 32'(line_r), ERR_CHAR, 1'b0};
            cnt = cnt + 2'd1;
          end
        end
      end
      if (ends) begin
        // Flush from the state the byte left behind.
        case (mode_nxt)
          M_SLASH: begin
            t[cnt] = '{K_SLASH, 32'(start_nxt), 32'(pos_nxt - start_nxt),
                       32'(line_nxt), ERR_NONE, 1'b0};
            cnt = cnt + 2'd1;
          end
          M_OPER: begin
            t[cnt] = '{oper_kind(op_nxt), 32'(start_nxt), 32'(pos_nxt - start_nxt),
                       32'(line_nxt), ERR_NONE, 1'b0};
            cnt = cnt + 2'd1;
          end
          M_STRING: begin
            t[cnt] = '{K_ERROR, 32'd0, 32'd0, 32'(line_nxt), ERR_STRING, 1'b0};
            cnt = cnt + 2'd1;
          end
          M_INT, M_FRAC: begin
            t[cnt] = '{K_NUMBER, 32'(start_nxt), 32'(pos_nxt - start_nxt),
                       32'(line_nxt), ERR_NONE, 1'b0};
            cnt = cnt + 2'd1;
          end
          M_IDENT: begin
            t[cnt] = '{word_kind(kw_nxt, (pos_nxt - start_nxt > POSITION_BITS'(6)) ? 3'd7
                       : 3'(pos_nxt - start_nxt)), 32'(start_nxt),
                       32'(pos_nxt - start_nxt), 32'(line_nxt), ERR_NONE, 1'b0};
            cnt = cnt + 2'd1;
          end
          default: ;
        endcase
        t[cnt] = '{K_EOF, 32'(pos_nxt), 32'd0, 32'(line_nxt), ERR_NONE, 1'b0};
        cnt = cnt + 2'd1;
        mode_nxt = M_IDLE; start_nxt = pos_nxt; fin_nxt = 1'b1;
      end
      if (cnt != 2'd0) t[cnt - 2'd1].last = 1'b1;
    end
  end

  assign n_tok = cnt;
  assign tok0  = t[0];
  assign tok1  = t[1];
  assign tok2  = t[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; start_r <= '0;
      line_r <= LINE_BITS'(1); kw_r <= '0; op_r <= '0; fin_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; start_r <= start_nxt;
      line_r <= line_nxt; kw_r <= kw_nxt; op_r <= op_nxt; fin_r <= fin_nxt;
    end
  end
endmodule

// ===== hdl/slx_queue.sv =====
// Token queue: takes up to three requests per cycle, gives one per cycle while pop is high.
module slx_queue #(
  parameter int DEPTH_BITS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    n_in,
  input  slx_pkg::tok_t in0,
  input  slx_pkg::tok_t in1,
  input  slx_pkg::tok_t in2,
  input  logic          pop,
  output logic          empty,
  output logic          room3,
  output slx_pkg::tok_t head
);
  import slx_pkg::*;

  localparam int DEPTH = 1 << DEPTH_BITS;

  tok_t                mem_r [DEPTH];
  logic [DEPTH_BITS-1:0] wp_r, rp_r;
  logic [DEPTH_BITS:0]   cnt_r, cnt_nxt;
  logic                  do_pop;

  assign empty  = (cnt_r == '0);
  assign room3  = (cnt_r <= (DEPTH_BITS+1)'(DEPTH - 3));
  assign head   = mem_r[rp_r];
  assign do_pop = pop && !empty;
  assign cnt_nxt = cnt_r + (DEPTH_BITS+1)'(n_in) - (DEPTH_BITS+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (n_in > 2'd0) mem_r[wp_r] <= in0;
    if (n_in > 2'd1) mem_r[wp_r + DEPTH_BITS'(1)] <= in1;
    if (n_in > 2'd2) mem_r[wp_r + DEPTH_BITS'(2)] <= in2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + DEPTH_BITS'(n_in);
      rp_r  <= rp_r + DEPTH_BITS'(do_pop);
      cnt_r <= cnt_nxt;
    end
  end
endmodule
